@@ rtl/core/buhs_pkg.sv @@
// ----------------------------------------------------------------------------
// buhs_pkg: shared types and constants of the bottom-up heap sorter
// Payload structs of both channels, configuration register indexes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package buhs_pkg;

  // Width of the key field on both channels.
  localparam int unsigned KEY_BITS = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SIGNED = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 4'd1;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] sorted_key;
    logic                last_out;
    logic                overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT_RD,
    S_ROOT_LD,
    S_SWAP_A,
    S_SWAP_B,
    S_SWAP_C,
    S_DESC,
    S_DESC_L,
    S_DESC_R,
    S_CLIMB_RD,
    S_CLIMB_CMP,
    S_ROT_RD,
    S_ROT_WR,
    S_FIN,
    S_OUT_RD,
    S_OUT_LD
  } state_e;

endpackage

@@ rtl/core/bottom_up_heap_sorter.sv @@
// ----------------------------------------------------------------------------
// bottom_up_heap_sorter: in-place bottom-up heapsort of a set of keys
// Loads keys into a single-port key memory, sorts them with one shared key
// comparator under a small sequencer, then streams them out in order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i): one key per transaction.
//   A transaction with last set closes the set and starts the sort. Keys
//   beyond MAX_ITEMS are dropped and flag overflow on every result of the set.
//   in_ready_o is high only while the block loads keys (state idle).
//   Output channel (out_valid_o/out_ready_i/out_data_o): one transaction per
//   key of the set, last_out set on the final one.
//   Config channel: index 0 selects signed compare, index 1 descending order;
//   write only while the block is idle. cfg_ready_o is always high.
// Operation:
//   Loading accepts keys back to back while idle. The sort is bounded by the
//   single read port of the key memory: each sift-down walks down to a leaf
//   along the child that ranks after (reading both children at each level),
//   climbs back until the carried key no longer ranks after the key on the
//   path, then rotates the path above that point. Output then reads each key
//   and registers it; while the receiver stalls, the result register holds
//   its transaction and the sequencer waits. A set of one key goes straight to output.
// Reset: asynchronous, active low; clears the set, the flags and the
//   configuration. The key memory is not cleared.
// ----------------------------------------------------------------------------
module bottom_up_heap_sorter #(
  parameter int unsigned MAX_ITEMS = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  buhs_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output buhs_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [buhs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [buhs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned NW = AW + 2;
  localparam int unsigned KB = buhs_pkg::KEY_BITS;

  buhs_pkg::state_e state_q, state_d;

  // Key memory
  logic [KEY_WIDTH-1:0] key_mem [MAX_ITEMS];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] rdata_q;

  // Control and scratch registers
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] heap_end_q, heap_end_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [AW-1:0] root_q, root_d;
  logic          building_q, building_d;
  logic [AW-1:0] out_idx_q, out_idx_d;
  logic          key_signed_q, key_signed_d;
  logic          descending_q, descending_d;
  logic          out_valid_q, out_valid_d;

  // Payload registers
  logic [KEY_WIDTH-1:0] hold_q, hold_d;
  logic [KEY_WIDTH-1:0] left_q, left_d;
  buhs_pkg::out_item_t  out_q, out_d;

  // Shared signals
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 store_ok;
  logic [CW-1:0]        count_inc;
  logic [CW-1:0]        root_start;
  logic [NW-1:0]        child_l;
  logic [NW-1:0]        child_r;
  logic [NW-1:0]        end_ext;
  logic                 desc_more;
  logic                 desc_leaf;
  logic                 walk_above;
  logic [AW-1:0]        walk_parent;
  logic [KEY_WIDTH-1:0] sign_mask;
  logic [KEY_WIDTH-1:0] cmp_x;
  logic [KEY_WIDTH-1:0] cmp_y;
  logic                 ranks_after;
  logic                 out_free;
  logic                 out_is_last;
  logic [KEY_WIDTH+KB-1:0] in_key_wide;
  logic [KEY_WIDTH+KB-1:0] out_key_wide;

  assign in_ready_o  = (state_q == buhs_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i & in_ready_o;
  assign cfg_acc     = cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign store_ok   = (count_q < CW'(MAX_ITEMS));
  assign count_inc  = store_ok ? (count_q + CW'(1)) : count_q;
  assign root_start = (count_inc - CW'(2)) >> 1;

  assign child_l     = (NW'(walk_q) << 1) + NW'(1);
  assign child_r     = child_l + NW'(1);
  assign end_ext     = NW'(heap_end_q);
  assign desc_more   = (child_r <= end_ext);
  assign desc_leaf   = (child_l <= end_ext);
  assign walk_above  = (walk_q > root_q);
  assign walk_parent = (walk_q - AW'(1)) >> 1;

  // Shared key comparator: does cmp_x rank after cmp_y?
  always_comb begin
    sign_mask                = '0;
    sign_mask[KEY_WIDTH-1]   = key_signed_q;
  end

  assign cmp_x = (state_q == buhs_pkg::S_DESC_R) ? (rdata_q ^ sign_mask) : (hold_q ^ sign_mask);
  assign cmp_y = (state_q == buhs_pkg::S_DESC_R) ? (left_q ^ sign_mask) : (rdata_q ^ sign_mask);
  assign ranks_after = descending_q ? (cmp_x < cmp_y) : (cmp_x > cmp_y);

  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_is_last = ((CW'(out_idx_q) + CW'(1)) == count_q);

  assign in_key_wide  = {{KEY_WIDTH{1'b0}}, in_data_i.key};
  assign out_key_wide = {{KB{1'b0}}, rdata_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      buhs_pkg::S_IDLE: begin
        if (in_acc && in_data_i.last) begin
          state_d = (count_inc >= CW'(2)) ? buhs_pkg::S_ROOT_RD : buhs_pkg::S_OUT_RD;
        end
      end
      buhs_pkg::S_ROOT_RD: state_d = buhs_pkg::S_ROOT_LD;
      buhs_pkg::S_ROOT_LD: state_d = buhs_pkg::S_DESC;
      buhs_pkg::S_SWAP_A:  state_d = buhs_pkg::S_SWAP_B;
      buhs_pkg::S_SWAP_B:  state_d = buhs_pkg::S_SWAP_C;
      buhs_pkg::S_SWAP_C:  state_d = buhs_pkg::S_DESC;
      buhs_pkg::S_DESC: begin
        state_d = desc_more ? buhs_pkg::S_DESC_L : buhs_pkg::S_CLIMB_RD;
      end
      buhs_pkg::S_DESC_L:  state_d = buhs_pkg::S_DESC_R;
      buhs_pkg::S_DESC_R:  state_d = buhs_pkg::S_DESC;
      buhs_pkg::S_CLIMB_RD: begin
        state_d = walk_above ? buhs_pkg::S_CLIMB_CMP : buhs_pkg::S_FIN;
      end
      buhs_pkg::S_CLIMB_CMP: begin
        state_d = ranks_after ? buhs_pkg::S_CLIMB_RD : buhs_pkg::S_ROT_RD;
      end
      buhs_pkg::S_ROT_RD: begin
        state_d = walk_above ? buhs_pkg::S_ROT_WR : buhs_pkg::S_FIN;
      end
      buhs_pkg::S_ROT_WR:  state_d = buhs_pkg::S_ROT_RD;
      buhs_pkg::S_FIN: begin
        if (building_q) begin
          state_d = (root_q == '0) ? buhs_pkg::S_SWAP_A : buhs_pkg::S_ROOT_RD;
        end else begin
          state_d = (heap_end_q == '0) ? buhs_pkg::S_OUT_RD : buhs_pkg::S_SWAP_A;
        end
      end
      buhs_pkg::S_OUT_RD:  state_d = buhs_pkg::S_OUT_LD;
      buhs_pkg::S_OUT_LD: begin
        if (out_free) begin
          state_d = out_is_last ? buhs_pkg::S_IDLE : buhs_pkg::S_OUT_RD;
        end
      end
      default: state_d = buhs_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = walk_q;
    mem_wdata    = hold_q;
    mem_re       = 1'b0;
    mem_raddr    = walk_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    heap_end_d   = heap_end_q;
    walk_d       = walk_q;
    root_d       = root_q;
    building_d   = building_q;
    out_idx_d    = out_idx_q;
    hold_d       = hold_q;
    left_d       = left_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    key_signed_d = key_signed_q;
    descending_d = descending_q;

    if (cfg_acc) begin
      if (cfg_index_i == buhs_pkg::CFG_KEY_SIGNED) begin
        key_signed_d = cfg_data_i[0];
      end else if (cfg_index_i == buhs_pkg::CFG_DESCENDING) begin
        descending_d = cfg_data_i[0];
      end
    end

    case (state_q)
      buhs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (store_ok) begin
            mem_we    = 1'b1;
            mem_waddr = count_q[AW-1:0];
            mem_wdata = in_key_wide[KEY_WIDTH-1:0];
            count_d   = count_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            heap_end_d = AW'(count_inc - CW'(1));
            root_d     = root_start[AW-1:0];
            building_d = 1'b1;
            out_idx_d  = '0;
          end
        end
      end
      buhs_pkg::S_ROOT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = root_q;
      end
      buhs_pkg::S_ROOT_LD: begin
        hold_d = rdata_q;
        walk_d = root_q;
      end
      // Swap root with the heap end: the root key moves to the end slot, the end key is sifted down
      buhs_pkg::S_SWAP_A: begin
        building_d = 1'b0;
        mem_re     = 1'b1;
        mem_raddr  = heap_end_q;
      end
      buhs_pkg::S_SWAP_B: begin
        hold_d    = rdata_q;
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      buhs_pkg::S_SWAP_C: begin
        mem_we     = 1'b1;
        mem_waddr  = heap_end_q;
        mem_wdata  = rdata_q;
        heap_end_d = heap_end_q - AW'(1);
        root_d     = '0;
        walk_d     = '0;
      end
      buhs_pkg::S_DESC: begin
        if (desc_more) begin
          mem_re    = 1'b1;
          mem_raddr = child_l[AW-1:0];
        end else if (desc_leaf) begin
          walk_d = child_l[AW-1:0];
        end
      end
      buhs_pkg::S_DESC_L: begin
        mem_re    = 1'b1;
        mem_raddr = child_r[AW-1:0];
        left_d    = rdata_q;
      end
      buhs_pkg::S_DESC_R: begin
        walk_d = ranks_after ? child_r[AW-1:0] : child_l[AW-1:0];
      end
      buhs_pkg::S_CLIMB_RD: begin
        if (walk_above) begin
          mem_re    = 1'b1;
          mem_raddr = walk_q;
        end
      end
      buhs_pkg::S_CLIMB_CMP: begin
        if (ranks_after) begin
          walk_d = walk_parent;
        end
      end
      buhs_pkg::S_ROT_RD: begin
        if (walk_above) begin
          mem_re    = 1'b1;
          mem_raddr = walk_q;
        end
      end
      // Rotate the path: drop the carried key here, carry the old one upward
      buhs_pkg::S_ROT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = walk_q;
        mem_wdata = hold_q;
        hold_d    = rdata_q;
        walk_d    = walk_parent;
      end
      buhs_pkg::S_FIN: begin
        mem_we    = 1'b1;
        mem_waddr = root_q;
        mem_wdata = hold_q;
        if (building_q && (root_q != '0)) begin
          root_d = root_q - AW'(1);
        end
      end
      buhs_pkg::S_OUT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = out_idx_q;
      end
      buhs_pkg::S_OUT_LD: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.sorted_key = out_key_wide[KB-1:0];
          out_d.last_out   = out_is_last;
          out_d.overflow   = ovf_q;
          if (out_is_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end else begin
            out_idx_d = out_idx_q + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= buhs_pkg::S_IDLE;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      heap_end_q   <= '0;
      walk_q       <= '0;
      root_q       <= '0;
      building_q   <= 1'b0;
      out_idx_q    <= '0;
      key_signed_q <= 1'b0;
      descending_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      heap_end_q   <= heap_end_d;
      walk_q       <= walk_d;
      root_q       <= root_d;
      building_q   <= building_d;
      out_idx_q    <= out_idx_d;
      key_signed_q <= key_signed_d;
      descending_q <= descending_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    left_q <= left_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= key_mem[mem_raddr];
    end
  end

endmodule
